// ===== hw/rtl/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared widths and codes for the open-addressed hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int KEY_W      = 32;
  localparam int HASH_W     = 32;
  localparam int VAL_W      = 64;
  localparam int SLOT_W     = 7;
  localparam int CNT_W      = 8;
  localparam int SK_W       = 2;
  localparam int META_W     = SK_W + KEY_W;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CNT_W-1:0] FILL_LIMIT_RST = 8'd96;

  // register select: bit 2 of the byte address
  localparam logic REG_FILL_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_SET   = 2'd1,
    OP_DEL   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // slot kinds as stored in the meta memory
  localparam logic [SK_W-1:0] SK_EMPTY = 2'd0;
  localparam logic [SK_W-1:0] SK_LIVE  = 2'd1;
  localparam logic [SK_W-1:0] SK_TOMB  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

endpackage

// ===== hw/rtl/oaht_if.sv =====
// ----------------------------------------------------------------------------
// oaht_req_if / oaht_rsp_if
// Valid/ready channels for table requests and responses.
// ----------------------------------------------------------------------------
interface oaht_req_if
  import oaht_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [KEY_W-1:0]  key_id;
  logic [HASH_W-1:0] key_hash;
  logic [VAL_W-1:0]  new_value;

  modport source (output valid, kind, key_id, key_hash, new_value, input ready);
  modport sink   (input valid, kind, key_id, key_hash, new_value, output ready);
endinterface

interface oaht_rsp_if
  import oaht_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              is_new;
  logic [VAL_W-1:0]  read_value;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, status, is_new, read_value, slot, input ready);
  modport sink   (input valid, status, is_new, read_value, slot, output ready);
endinterface

// ===== hw/rtl/open_address_hash_table.sv =====
// ----------------------------------------------------------------------------
// open_address_hash_table
// Linear-probing key/value table with tombstones, one response per request.
// ----------------------------------------------------------------------------
// A request (get, set, delete or clear) is taken only while the table is
// idle. A get/set/delete first issues the home-slot read on the accept
// cycle; the meta and value memories then deliver one slot per cycle while
// the probe visits between 1 slot (a key at or an empty slot in its home
// slot) and TABLE_SLOTS slots, and S_DONE posts the response beat into the
// output register once that register is free. Each memory has a single
// read port. A clear walks every slot and then posts its response. After
// reset the same clearing pass runs over every slot before the first
// request is taken; configuration writes are taken throughout. Occupancy
// counts live and tombstone slots; a set that would fill an empty slot past
// fill_limit answers full and writes nothing.
// ----------------------------------------------------------------------------
module open_address_hash_table
  import oaht_pkg::*;
#(
  parameter int TABLE_SLOTS = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // channels
  oaht_req_if.sink              req,
  oaht_rsp_if.source            rsp
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  state_t state;

  // ---------------------------------------------------------------- config
  logic [CNT_W-1:0] fill_limit;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FILL_LIMIT) ?
                  {{(APB_DATA_W-CNT_W){1'b0}}, fill_limit} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_limit <= FILL_LIMIT_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_FILL_LIMIT) begin
      fill_limit <= pwdata[CNT_W-1:0];
    end
  end

  // --------------------------------------------------------------- memories
  // meta = {slot kind, key}; value held apart. Both read at the same address.
  logic [META_W-1:0] meta_mem [TABLE_SLOTS];
  logic [VAL_W-1:0]  value_mem [TABLE_SLOTS];

  logic [IDX_W-1:0]  raddr;
  logic [META_W-1:0] meta_rd;
  logic [VAL_W-1:0]  value_rd;

  logic              mwe;
  logic [IDX_W-1:0]  mwaddr;
  logic [META_W-1:0] mwdata;
  logic              vwe;
  logic [IDX_W-1:0]  vwaddr;
  logic [VAL_W-1:0]  vwdata;

  always_ff @(posedge clk) begin
    if (mwe) begin
      meta_mem[mwaddr] <= mwdata;
    end
    meta_rd <= meta_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      value_mem[vwaddr] <= vwdata;
    end
    value_rd <= value_mem[raddr];
  end

  // ------------------------------------------------------------ request regs
  op_t              op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;

  logic [IDX_W-1:0] sweep_addr;
  logic             clr_pending;
  logic [CNT_W-1:0] used_count;

  logic [IDX_W-1:0] pidx;        // slot whose data sits on the read ports
  logic [IDX_W-1:0] visits;      // slots already passed in this probe
  logic             tomb_seen;
  logic [IDX_W-1:0] tomb_idx;

  logic [1:0]       res_status;
  logic             res_new;
  logic [VAL_W-1:0] res_value;
  logic [IDX_W-1:0] res_slot;

  logic              out_valid;
  logic [1:0]        out_status;
  logic              out_new;
  logic [VAL_W-1:0]  out_value;
  logic [SLOT_W-1:0] out_slot;

  // index truncated/extended to the response width
  logic [IDX_W+SLOT_W-1:0] slot_ext;
  assign slot_ext = {{SLOT_W{1'b0}}, res_slot};

  // home-slot read on the accept cycle, then one slot per cycle with wrap
  assign raddr = (state == S_IDLE) ? req.key_hash[IDX_W-1:0] : pidx + IDX_W'(1);

  // ------------------------------------------------------------ probe check
  logic [SK_W-1:0]  pkind;
  logic [KEY_W-1:0] pkey;
  logic             is_empty;
  logic             is_hit;
  logic             is_tomb;
  logic             last_visit;
  logic             probe_end;
  logic             tseen_now;
  logic [IDX_W-1:0] tgt_idx;
  logic             tgt_empty;
  logic             have_tgt;
  logic             over_limit;
  logic             full;
  logic             count_inc;

  logic [1:0]       pr_status;
  logic             pr_new;
  logic [VAL_W-1:0] pr_value;
  logic [IDX_W-1:0] pr_slot;

  assign pkind      = meta_rd[META_W-1:KEY_W];
  assign pkey       = meta_rd[KEY_W-1:0];
  assign is_empty   = (pkind == SK_EMPTY);
  assign is_hit     = (pkind == SK_LIVE) && (pkey == key_q);
  // any non-empty, non-live code counts as a tombstone
  assign is_tomb    = !is_empty && (pkind != SK_LIVE);
  assign last_visit = &visits;
  assign probe_end  = is_empty || is_hit || last_visit;

  assign tseen_now  = tomb_seen || is_tomb;
  assign tgt_idx    = tomb_seen ? tomb_idx : pidx;
  assign tgt_empty  = is_empty && !tomb_seen;
  assign have_tgt   = is_empty || tseen_now;
  assign over_limit = ({1'b0, used_count} + 9'd1) > {1'b0, fill_limit};
  assign full       = !have_tgt || (tgt_empty && over_limit);

  always_comb begin
    pr_status = ST_OK;
    pr_new    = 1'b0;
    pr_value  = '0;
    pr_slot   = '0;
    mwe       = 1'b0;
    mwaddr    = pidx;
    mwdata    = {SK_LIVE, key_q};
    vwe       = 1'b0;
    vwaddr    = pidx;
    vwdata    = value_q;
    count_inc = 1'b0;

    if (state == S_SWEEP) begin
      mwe    = 1'b1;
      mwaddr = sweep_addr;
      mwdata = {SK_EMPTY, {KEY_W{1'b0}}};
    end else if (state == S_PROBE && probe_end) begin
      case (op_q)
        OP_GET: begin
          if (is_hit) begin
            pr_value = value_rd;
            pr_slot  = pidx;
          end else begin
            pr_status = ST_MISS;
          end
        end
        OP_DEL: begin
          if (is_hit) begin
            mwe     = 1'b1;
            mwdata  = {SK_TOMB, key_q};   // value left in place
            pr_slot = pidx;
          end else begin
            pr_status = ST_MISS;
          end
        end
        OP_SET: begin
          if (is_hit) begin
            vwe     = 1'b1;
            pr_slot = pidx;
          end else if (full) begin
            pr_status = ST_FULL;
          end else begin
            mwe       = 1'b1;
            mwaddr    = tgt_idx;
            vwe       = 1'b1;
            vwaddr    = tgt_idx;
            count_inc = tgt_empty;
            pr_new    = 1'b1;
            pr_slot   = tgt_idx;
          end
        end
        default: begin
          pr_status = ST_OK;
        end
      endcase
    end
  end

  // ---------------------------------------------------------- state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_addr  <= '0;
      clr_pending <= 1'b0;
      used_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      // S_DONE drives out_valid itself
      if (rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + IDX_W'(1);
          if (&sweep_addr) begin
            state       <= clr_pending ? S_DONE : S_IDLE;
            clr_pending <= 1'b0;
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            op_q      <= op_t'(req.kind);
            key_q     <= req.key_id;
            value_q   <= req.new_value;
            pidx      <= req.key_hash[IDX_W-1:0];
            visits    <= '0;
            tomb_seen <= 1'b0;
            tomb_idx  <= '0;
            if (op_t'(req.kind) == OP_CLEAR) begin
              state       <= S_SWEEP;
              sweep_addr  <= '0;
              clr_pending <= 1'b1;
              used_count  <= '0;
              res_status  <= ST_OK;
              res_new     <= 1'b0;
              res_value   <= '0;
              res_slot    <= '0;
            end else begin
              state <= S_PROBE;
            end
          end
        end

        S_PROBE: begin
          if (probe_end) begin
            state      <= S_DONE;
            res_status <= pr_status;
            res_new    <= pr_new;
            res_value  <= pr_value;
            res_slot   <= pr_slot;
            if (count_inc) begin
              used_count <= used_count + CNT_W'(1);
            end
          end else begin
            pidx      <= pidx + IDX_W'(1);
            visits    <= visits + IDX_W'(1);
            tomb_seen <= tseen_now;
            tomb_idx  <= tgt_idx;
          end
        end

        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state      <= S_IDLE;
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_new    <= res_new;
            out_value  <= res_value;
            out_slot   <= slot_ext[SLOT_W-1:0];
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.is_new     = out_new;
  assign rsp.read_value = out_value;
  assign rsp.slot       = out_slot;

  // ------------------------------------------------------------- assertions
  // no memory writes while waiting for a request
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!mwe && !vwe))
    else $error("memory written while idle");

  // occupancy only steps up by one or drops to zero on clear
  assert property (@(posedge clk) disable iff (rst)
    (used_count != $past(used_count)) |->
      (used_count == $past(used_count) + CNT_W'(1) || used_count == '0))
    else $error("occupancy count moved unexpectedly");

  // failed requests report slot 0 and no new key
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.slot == '0 && !rsp.is_new))
    else $error("failed response carries slot or new flag");

  // a new key is always a set that wrote the meta memory
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && probe_end && pr_new) |-> (mwe && vwe && op_q == OP_SET))
    else $error("new key without table write");

endmodule
